// ----- rtl/core/rps_pkg.sv -----
// Package for the repeat payload suppressor: sizes, codes and the item record
// that passes from the stream front end to the match evaluation stage.
// No dependencies.
package rps_pkg;

  // Largest payload that is stored and compared, in bytes
  localparam int MAX_PAYLOAD = 1024;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);

  // Field widths fixed by the interface
  localparam int POS_W  = 11;
  localparam int LEN_W  = 12;
  localparam int ECI_W  = 20;
  localparam int TYPE_W = 4;
  localparam int TIME_W = 48;
  localparam int WIN_W  = 16;

  localparam logic [POS_W-1:0] POS_MAX     = '1;
  localparam logic [LEN_W-1:0] LEN_LIMIT   = LEN_W'(MAX_PAYLOAD);
  localparam logic [WIN_W-1:0] WIN_RESET   = 16'd2000;

  // Item kinds
  localparam logic KIND_CHECK  = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  // One accepted beat, with the position bookkeeping already worked out
  typedef struct packed {
    logic              is_record;
    logic              in_range;
    logic              last;
    logic              len_ok;
    logic              enough;
    logic [7:0]        data_byte;
    logic [LEN_W-1:0]  len;
    logic [ECI_W-1:0]  eci;
    logic [TYPE_W-1:0] code_type;
    logic [TIME_W-1:0] now;
  } rps_item_t;

endpackage

// ----- rtl/core/rps_byte_store.sv -----
// Single-port byte store holding the recorded payload, with registered read.
// Depends on rps_pkg for its depth.
module rps_byte_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic                      re,
  input  logic [rps_pkg::ADDR_W-1:0] addr,
  input  logic [7:0]                wdata,
  output logic [7:0]                rdata
);

  logic [7:0] mem [rps_pkg::MAX_PAYLOAD];

  // Write port; the contents are undefined until written.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port; the data holds between reads.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/core/rps_stream_ctrl.sv -----
// Front end: tracks the byte position within a payload, issues the byte store
// access for each accepted beat and holds the beat for the evaluation stage.
// Depends on rps_pkg.
module rps_stream_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          advance,
  input  logic                          kind,
  input  logic [7:0]                    data_byte,
  input  logic                          last_byte,
  input  logic [rps_pkg::LEN_W-1:0]     payload_length,
  input  logic [rps_pkg::ECI_W-1:0]     eci_value,
  input  logic [rps_pkg::TYPE_W-1:0]    code_type,
  input  logic [rps_pkg::TIME_W-1:0]    now_ms,
  output logic                          s1_valid,
  output rps_pkg::rps_item_t            s1_item,
  output logic                          mem_we,
  output logic                          mem_re,
  output logic [rps_pkg::ADDR_W-1:0]    mem_addr,
  output logic [7:0]                    mem_wdata
);

  logic [rps_pkg::POS_W-1:0] pos;
  logic [rps_pkg::POS_W-1:0] pos_next;
  logic [rps_pkg::LEN_W-1:0] pos_ext;
  rps_pkg::rps_item_t        item;

  // Classify the incoming beat against the current position.
  always_comb begin
    pos_ext         = {1'b0, pos};
    item.is_record  = (kind == rps_pkg::KIND_RECORD);
    item.len_ok     = (payload_length <= rps_pkg::LEN_LIMIT);
    item.in_range   = (pos_ext < payload_length) && item.len_ok;
    item.enough     = ((pos_ext + 1'b1) >= payload_length);
    item.last       = last_byte;
    item.data_byte  = data_byte;
    item.len        = payload_length;
    item.eci        = eci_value;
    item.code_type  = code_type;
    item.now        = now_ms;
  end

  // Byte store access: records write at once, checks read for the next stage.
  assign mem_addr  = pos[rps_pkg::ADDR_W-1:0];
  assign mem_wdata = data_byte;
  assign mem_we    = accept && item.is_record && item.in_range;
  assign mem_re    = accept && !item.is_record;

  // Position restarts after a final beat and saturates otherwise.
  always_comb begin
    pos_next = pos;
    if (accept) begin
      if (last_byte) begin
        pos_next = '0;
      end else if (pos != rps_pkg::POS_MAX) begin
        pos_next = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
    end else begin
      pos <= pos_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Beat register for the evaluation stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
  end

endmodule

// ----- rtl/core/rps_match_eval.sv -----
// Evaluation stage: compares the read byte, keeps the stored header, the
// valid mark and the running match flag, and drives the result register.
// Depends on rps_pkg.
module rps_match_eval (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s1_valid,
  input  rps_pkg::rps_item_t         s1_item,
  input  logic [7:0]                 rd_byte,
  input  logic [rps_pkg::WIN_W-1:0]  window,
  input  logic                       out_ready,
  output logic                       advance,
  output logic                       out_valid,
  output logic                       send_allowed
);

  logic [rps_pkg::POS_W-1:0]  stored_length;
  logic [rps_pkg::ECI_W-1:0]  stored_eci;
  logic [rps_pkg::TYPE_W-1:0] stored_type;
  logic [rps_pkg::TIME_W-1:0] last_seen_time;
  logic                       entry_valid;
  logic                       bytes_match;

  logic                       produces;
  logic                       match_all;
  logic [rps_pkg::TIME_W:0]   age;
  logic                       in_window;
  logic                       hit;
  logic                       send_next;

  // A final check beat needs a free result register before it can retire.
  assign produces = s1_item.last && !s1_item.is_record;
  assign advance  = s1_valid && !(produces && out_valid && !out_ready);

  // Byte compare and the suppression decision.
  always_comb begin
    match_all = bytes_match;
    if (!s1_item.is_record && s1_item.in_range && (rd_byte != s1_item.data_byte)) begin
      match_all = 1'b0;
    end
    age       = {1'b0, s1_item.now} - {1'b0, last_seen_time};
    in_window = !age[rps_pkg::TIME_W] &&
                (age[rps_pkg::TIME_W-1:0] < {{(rps_pkg::TIME_W-rps_pkg::WIN_W){1'b0}}, window});
    hit       = entry_valid && s1_item.enough && match_all &&
                ({1'b0, stored_length} == s1_item.len) &&
                (stored_eci == s1_item.eci) && (stored_type == s1_item.code_type) &&
                in_window;
    send_next = s1_item.len_ok && !hit;
  end

  // Control state, updated as each beat retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      bytes_match <= 1'b1;
    end else if (advance) begin
      if (!s1_item.last) begin
        bytes_match <= match_all;
        if (s1_item.is_record && s1_item.in_range) begin
          entry_valid <= 1'b0;
        end
      end else begin
        bytes_match <= 1'b1;
        if (s1_item.is_record) begin
          if (s1_item.len_ok) begin
            entry_valid <= s1_item.enough;
          end
        end else if (s1_item.len_ok && !hit) begin
          entry_valid <= 1'b0;
        end
      end
    end
  end

  // Stored header and last-seen time.
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_length  <= '0;
      stored_eci     <= '0;
      stored_type    <= '0;
      last_seen_time <= '0;
    end else if (advance && s1_item.last) begin
      if (s1_item.is_record && s1_item.len_ok) begin
        stored_length  <= s1_item.len[rps_pkg::POS_W-1:0];
        stored_eci     <= s1_item.eci;
        stored_type    <= s1_item.code_type;
        last_seen_time <= s1_item.now;
      end else if (!s1_item.is_record && s1_item.len_ok && hit) begin
        last_seen_time <= s1_item.now;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produces) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produces) begin
      send_allowed <= send_next;
    end
  end

endmodule

// ----- rtl/core/repeat_payload_suppressor.sv -----
// Repeat payload suppressor.
// Payloads arrive on the input channel one byte per beat, with the length,
// ECI, type and a millisecond time on every beat; kind selects check or
// record and last_byte marks the final beat. A check gives one beat on the
// output channel when its final beat retires: send_allowed is 0 for a repeat
// of the stored payload seen within the rearm window (or for an over-long
// payload) and 1 otherwise. A record stores the payload as the new reference.
// The configuration channel writes the rearm window in milliseconds; it is
// always ready and should be written only while the block is idle.
// A result passes from the beat register of the front end to the result register.
// Throughput: one beat per cycle while the result register is not blocked, bounded
// by the single port of the byte store, which a record writes on acceptance and a
// check reads then for the compare in the next stage.
// Reset clears the valid mark, the position and the pipeline, and sets the
// window to 2000 ms; the byte store is not cleared.
// When the receiver stalls, the result register holds its beat; non-final
// beats keep flowing, and input is held only when a further result is ready.
module repeat_payload_suppressor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [7:0]                    data_byte,
  input  logic                          last_byte,
  input  logic [rps_pkg::LEN_W-1:0]     payload_length,
  input  logic [rps_pkg::ECI_W-1:0]     eci_value,
  input  logic [rps_pkg::TYPE_W-1:0]    code_type,
  input  logic [rps_pkg::TIME_W-1:0]    now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          send_allowed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rps_pkg::WIN_W-1:0]     cfg_data
);

  logic                         accept;
  logic                         advance;
  logic                         s1_valid;
  rps_pkg::rps_item_t           s1_item;
  logic                         mem_we;
  logic                         mem_re;
  logic [rps_pkg::ADDR_W-1:0]   mem_addr;
  logic [7:0]                   mem_wdata;
  logic [7:0]                   rd_byte;
  logic [rps_pkg::WIN_W-1:0]    rearm_window_ms;

  // Input handshake: the evaluation stage is free or retires this cycle.
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  // Rearm window register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rearm_window_ms <= rps_pkg::WIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rearm_window_ms <= cfg_data;
    end
  end

  rps_stream_ctrl u_stream_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .advance        (advance),
    .kind           (kind),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .payload_length (payload_length),
    .eci_value      (eci_value),
    .code_type      (code_type),
    .now_ms         (now_ms),
    .s1_valid       (s1_valid),
    .s1_item        (s1_item),
    .mem_we         (mem_we),
    .mem_re         (mem_re),
    .mem_addr       (mem_addr),
    .mem_wdata      (mem_wdata)
  );

  rps_byte_store u_byte_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (rd_byte)
  );

  rps_match_eval u_match_eval (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item),
    .rd_byte      (rd_byte),
    .window       (rearm_window_ms),
    .out_ready    (out_ready),
    .advance      (advance),
    .out_valid    (out_valid),
    .send_allowed (send_allowed)
  );

endmodule

// ----- rtl/core/rps_checker.sv -----
// Port-level checks for the repeat payload suppressor, bound to the top level.
// Depends on repeat_payload_suppressor.
module rps_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic send_allowed
);

  // A result beat held by the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(send_allowed))
    else $error("result beat changed while stalled");

  // Input is only ever held back by a blocked result register.
  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  // Reset leaves the pipeline empty and ready.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind repeat_payload_suppressor rps_checker u_rps_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .send_allowed (send_allowed)
);

// ----- test/testbench.sv -----
// Self-checking testbench for repeat_payload_suppressor: drives check and record payloads
// as beats, predicts every send decision and compares each result beat against it.
// Depends on rps_pkg and the repeat_payload_suppressor RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Sizes and codes taken from the package.
  localparam int MAX_PAYLOAD = rps_pkg::MAX_PAYLOAD;
  localparam int ADDR_W      = rps_pkg::ADDR_W;
  localparam int POS_W       = rps_pkg::POS_W;
  localparam int LEN_W       = rps_pkg::LEN_W;
  localparam int ECI_W       = rps_pkg::ECI_W;
  localparam int TYPE_W      = rps_pkg::TYPE_W;
  localparam int TIME_W      = rps_pkg::TIME_W;
  localparam int WIN_W       = rps_pkg::WIN_W;

  localparam logic [POS_W-1:0] POS_MAX   = rps_pkg::POS_MAX;
  localparam logic [LEN_W-1:0] LEN_LIMIT = rps_pkg::LEN_LIMIT;
  localparam logic [WIN_W-1:0] WIN_RESET = rps_pkg::WIN_RESET;

  localparam logic KIND_CHECK  = rps_pkg::KIND_CHECK;
  localparam logic KIND_RECORD = rps_pkg::KIND_RECORD;

  localparam int NO_PIN      = -1;
  localparam int DIR_ROWS    = 25;
  localparam int CYCLE_LIMIT = 400000;

  // One input beat as the block sees it on its ports.
  typedef struct packed {
    logic              kind;
    logic [7:0]        data;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [ECI_W-1:0]  eci;
    logic [TYPE_W-1:0] ctype;
    logic [TIME_W-1:0] now;
  } beat_t;

  // A directed beat with the send decision pinned where it is obvious.
  typedef struct {
    beat_t b;
    int    pin;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              kind = KIND_CHECK;
  logic [7:0]        data_byte = '0;
  logic              last_byte = 1'b0;
  logic [LEN_W-1:0]  payload_length = '0;
  logic [ECI_W-1:0]  eci_value = '0;
  logic [TYPE_W-1:0] code_type = '0;
  logic [TIME_W-1:0] now_ms = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              send_allowed;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [WIN_W-1:0]  cfg_data = '0;

  int beat_pin = NO_PIN;
  int beats_sent = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int stall_left = 0;
  bit idle_off = 1'b0;

  // Predicted send decisions, oldest first.
  bit expected_sends [$];

  // Shadow copy of the suppressor state.
  logic [WIN_W-1:0]  m_win = WIN_RESET;
  logic [7:0]        m_bytes [MAX_PAYLOAD];
  bit                m_written [MAX_PAYLOAD];
  logic [POS_W-1:0]  m_len = '0;
  logic [ECI_W-1:0]  m_eci = '0;
  logic [TYPE_W-1:0] m_type = '0;
  logic [TIME_W-1:0] m_last_seen = '0;
  bit                m_valid = 1'b0;
  logic [POS_W-1:0]  m_pos = '0;
  bit                m_match = 1'b1;

  // Payload being sent, and the last payload recorded, for building repeats.
  logic [7:0]        pay [2048];
  logic [7:0]        kept [MAX_PAYLOAD];
  int                kept_len = 0;
  logic [ECI_W-1:0]  kept_eci = '0;
  logic [TYPE_W-1:0] kept_type = '0;

  // Directed beats: empty and over-long payloads, the window edge, a byte mismatch,
  // time going back, bytes past the length, a short stream and a length at the limit.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{KIND_CHECK,  8'h00, 1'b1, 12'd0,    20'd0,      4'd0,  48'd0},               1},
    '{'{KIND_CHECK,  8'hFF, 1'b1, 12'd2048, 20'd999999, 4'd15, 48'hFFFF_FFFF_FFFF}, 0},
    '{'{KIND_CHECK,  8'h5A, 1'b1, 12'd1025, 20'd0,      4'd0,  48'd10},              0},
    '{'{KIND_RECORD, 8'h11, 1'b1, 12'd2048, 20'd7,      4'd3,  48'd20},              NO_PIN},
    '{'{KIND_RECORD, 8'h00, 1'b1, 12'd0,    20'd999999, 4'd15, 48'd100},             NO_PIN},
    '{'{KIND_CHECK,  8'hEE, 1'b1, 12'd0,    20'd999999, 4'd15, 48'd100},             0},
    '{'{KIND_RECORD, 8'hFF, 1'b0, 12'd2,    20'd0,      4'd0,  48'd5000},            NO_PIN},
    '{'{KIND_RECORD, 8'h00, 1'b1, 12'd2,    20'd0,      4'd0,  48'd5000},            NO_PIN},
    '{'{KIND_CHECK,  8'hFF, 1'b0, 12'd2,    20'd0,      4'd0,  48'd6999},            NO_PIN},
    '{'{KIND_CHECK,  8'h00, 1'b1, 12'd2,    20'd0,      4'd0,  48'd6999},            0},
    '{'{KIND_CHECK,  8'hFF, 1'b0, 12'd2,    20'd0,      4'd0,  48'd8999},            NO_PIN},
    '{'{KIND_CHECK,  8'h00, 1'b1, 12'd2,    20'd0,      4'd0,  48'd8999},            1},
    '{'{KIND_CHECK,  8'hFF, 1'b0, 12'd2,    20'd0,      4'd0,  48'd9000},            NO_PIN},
    '{'{KIND_CHECK,  8'h00, 1'b1, 12'd2,    20'd0,      4'd0,  48'd9000},            1},
    '{'{KIND_RECORD, 8'h80, 1'b1, 12'd1,    20'd1,      4'd1,  48'hFFFF_FFFF_FFFF}, NO_PIN},
    '{'{KIND_CHECK,  8'h7F, 1'b1, 12'd1,    20'd1,      4'd1,  48'hFFFF_FFFF_FFFF}, 1},
    '{'{KIND_RECORD, 8'h80, 1'b1, 12'd1,    20'd1,      4'd1,  48'd1000},            NO_PIN},
    '{'{KIND_CHECK,  8'h80, 1'b1, 12'd1,    20'd1,      4'd1,  48'd999},             1},
    '{'{KIND_RECORD, 8'h3C, 1'b0, 12'd1,    20'd5,      4'd2,  48'd2000},            NO_PIN},
    '{'{KIND_RECORD, 8'hC3, 1'b1, 12'd1,    20'd5,      4'd2,  48'd2000},            NO_PIN},
    '{'{KIND_CHECK,  8'h3C, 1'b0, 12'd1,    20'd5,      4'd2,  48'd2500},            NO_PIN},
    '{'{KIND_CHECK,  8'h99, 1'b1, 12'd1,    20'd5,      4'd2,  48'd2500},            0},
    '{'{KIND_RECORD, 8'h12, 1'b1, 12'd2,    20'd5,      4'd2,  48'd3000},            NO_PIN},
    '{'{KIND_CHECK,  8'h12, 1'b1, 12'd2,    20'd5,      4'd2,  48'd3000},            1},
    '{'{KIND_CHECK,  8'h12, 1'b1, 12'd1024, 20'd5,      4'd2,  48'd3000},            NO_PIN}
  };

  repeat_payload_suppressor u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .payload_length (payload_length),
    .eci_value      (eci_value),
    .code_type      (code_type),
    .now_ms         (now_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .send_allowed   (send_allowed),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Cycle counter; running past the limit means the block has hung.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[repeat_payload_suppressor] ERROR");
      $finish;
    end
  end

  // Advances the shadow state by one accepted beat and says whether a decision results.
  function automatic void suppress_beat(input beat_t b, output bit produced, output bit send);
    bit len_ok, in_range, enough, match_all, hit;
    len_ok    = b.len <= LEN_LIMIT;
    in_range  = len_ok && ({1'b0, m_pos} < b.len);
    enough    = ({1'b0, m_pos} + 12'd1) >= b.len;
    match_all = m_match;
    produced  = 1'b0;
    send      = 1'b0;
    if (b.kind == KIND_CHECK) begin
      if (in_range && m_bytes[m_pos[ADDR_W-1:0]] != b.data) match_all = 1'b0;
    end else if (in_range) begin
      m_bytes[m_pos[ADDR_W-1:0]]   = b.data;
      m_written[m_pos[ADDR_W-1:0]] = 1'b1;
      m_valid = 1'b0;
    end
    if (!b.last) begin
      m_match = match_all;
      if (m_pos != POS_MAX) m_pos++;
      return;
    end
    if (b.kind == KIND_CHECK) begin
      produced = 1'b1;
      if (len_ok) begin
        hit = m_valid && enough && match_all && {1'b0, m_len} == b.len &&
              m_eci == b.eci && m_type == b.ctype && b.now >= m_last_seen &&
              (b.now - m_last_seen) < TIME_W'(m_win);
        if (hit) begin
          m_last_seen = b.now;
        end else begin
          m_valid = 1'b0;
          send    = 1'b1;
        end
      end
    end else if (len_ok) begin
      m_len       = b.len[POS_W-1:0];
      m_eci       = b.eci;
      m_type      = b.ctype;
      m_last_seen = b.now;
      m_valid     = enough;
    end
    m_pos   = '0;
    m_match = 1'b1;
  endfunction

  // Result beats are checked first, then the window write and the input beat.
  always @(posedge clk) begin : monitor
    beat_t seen;
    bit    produced, send;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_sends.size() == 0) begin
          $error("send_allowed: result beat with nothing expected, got %0d", send_allowed);
          fail_cnt++;
        end else if (send_allowed !== expected_sends[0]) begin
          $error("send_allowed: expected %0d, got %0d", expected_sends[0], send_allowed);
          fail_cnt++;
          void'(expected_sends.pop_front());
        end else begin
          void'(expected_sends.pop_front());
        end
      end
      if (cfg_valid && cfg_ready) m_win = cfg_data;
      if (in_valid && in_ready) begin
        seen = '{kind, data_byte, last_byte, payload_length, eci_value, code_type, now_ms};
        suppress_beat(seen, produced, send);
        if (produced) expected_sends.push_back(beat_pin == NO_PIN ? send : beat_pin[0]);
      end
    end
  end

  // Result side: mostly ready, with short random stalls.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!idle_off && $urandom_range(99) < 7) begin
      stall_left = $urandom_range(5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Presents one beat, after an occasional gap, and returns at the falling edge after
  // it is taken. A check must never compare against a store entry that was never
  // written, so such a beat has its length cut back to the current position.
  task automatic drive_beat(input beat_t b, input int pin);
    if (!idle_off && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    if (b.kind == KIND_CHECK && b.len <= LEN_LIMIT && {1'b0, m_pos} < b.len &&
        !m_written[m_pos[ADDR_W-1:0]])
      b.len = {1'b0, m_pos};
    kind           <= b.kind;
    data_byte      <= b.data;
    last_byte      <= b.last;
    payload_length <= b.len;
    eci_value      <= b.eci;
    code_type      <= b.ctype;
    now_ms         <= b.now;
    beat_pin       <= pin;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  // Sends a whole payload of n beats taken from pay; bytes past the length are random.
  task automatic send_stream(input logic k, input int len, input int n,
                             input logic [ECI_W-1:0] eci, input logic [TYPE_W-1:0] ct,
                             input logic [TIME_W-1:0] t);
    beat_t b;
    for (int i = 0; i < n; i++) begin
      b.kind  = k;
      b.data  = (i < len && i < 2048) ? pay[i] : 8'($urandom);
      b.last  = (i == n - 1);
      b.len   = LEN_W'(len);
      b.eci   = eci;
      b.ctype = ct;
      b.now   = t;
      drive_beat(b, NO_PIN);
    end
  endtask

  // Keeps a copy of a recorded payload so that later checks can repeat it.
  task automatic remember(input int len, input logic [ECI_W-1:0] eci,
                          input logic [TYPE_W-1:0] ct);
    for (int i = 0; i < len; i++) kept[i] = pay[i];
    kept_len  = len;
    kept_eci  = eci;
    kept_type = ct;
  endtask

  // Waits until every decision is in, lets the pipeline empty, then writes the window.
  task automatic write_window(input logic [WIN_W-1:0] value);
    in_valid <= 1'b0;
    while (expected_sends.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly short payloads, now and then a longer or an over-long one.
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 30) return $urandom_range(3);
    if (r < 88) return $urandom_range(24, 4);
    if (r < 95) return $urandom_range(100, 25);
    return $urandom_range(2048, 1025);
  endfunction

  // Beats in a stream: one per byte, sometimes cut short or padded past the length.
  function automatic int stream_items(input int len);
    int r;
    if (len > MAX_PAYLOAD) return $urandom_range(3, 1);
    r = $urandom_range(99);
    if (r < 10 && len >= 2) return $urandom_range(len - 1, 1);
    if (r < 15) return (len == 0 ? 1 : len) + $urandom_range(3, 1);
    return len == 0 ? 1 : len;
  endfunction

  // A time for a repeat: on the window edges, inside, well past, or before last seen.
  function automatic logic [TIME_W-1:0] repeat_time();
    int unsigned w;
    w = m_win;
    unique case ($urandom_range(5))
      0: return m_last_seen;
      1: return m_last_seen + TIME_W'(w == 0 ? 0 : w - 1);
      2: return m_last_seen + TIME_W'(w);
      3: return m_last_seen + TIME_W'(w + $urandom_range(100000, 1));
      4: return m_last_seen + TIME_W'($urandom_range(w));
      default: return m_last_seen - TIME_W'($urandom_range(50, 1));
    endcase
  endfunction

  // Records, checks that repeat the last record (some altered), and loose noise beats.
  task automatic random_phase(input int quota);
    int                start, r, len, n, mut;
    logic [ECI_W-1:0]  eci;
    logic [TYPE_W-1:0] ct;
    logic [TIME_W-1:0] t;
    beat_t             b;
    start = beats_sent;
    while (beats_sent - start < quota) begin
      r = $urandom_range(99);
      if (r < 35) begin
        len = pick_len();
        for (int i = 0; i < len && i < 2048; i++) pay[i] = 8'($urandom);
        eci = ECI_W'($urandom_range(999999));
        ct  = TYPE_W'($urandom);
        t   = ($urandom_range(19) == 0) ? TIME_W'({$urandom, $urandom}) :
              m_last_seen + TIME_W'($urandom_range(70000));
        if (len <= MAX_PAYLOAD) remember(len, eci, ct);
        send_stream(KIND_RECORD, len, stream_items(len), eci, ct, t);
      end else if (r < 85) begin
        for (int i = 0; i < kept_len; i++) pay[i] = kept[i];
        len = kept_len;
        eci = kept_eci;
        ct  = kept_type;
        mut = $urandom_range(99);
        if (mut < 8 && len > 0) begin
          pay[$urandom_range(len - 1)] ^= 8'(1 << $urandom_range(7));
        end else if (mut < 14) begin
          eci = ECI_W'((eci + 1) % 1000000);
        end else if (mut < 20) begin
          ct = ct + 1'b1;
        end else if (mut < 26) begin
          if ($urandom_range(1) == 1 || len == 0) begin
            len++;
            pay[len - 1] = 8'($urandom);
          end else begin
            len--;
          end
        end
        send_stream(KIND_CHECK, len, stream_items(len), eci, ct, repeat_time());
      end else begin
        n   = $urandom_range(6, 1);
        len = pick_len();
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(9) < 3) len = pick_len();
          b.kind  = 1'($urandom);
          b.data  = 8'($urandom);
          b.last  = (i == n - 1) ? ($urandom_range(9) < 7) : ($urandom_range(9) == 0);
          b.len   = LEN_W'(len);
          b.eci   = ECI_W'($urandom_range(999999));
          b.ctype = TYPE_W'($urandom);
          b.now   = repeat_time();
          drive_beat(b, NO_PIN);
        end
      end
    end
  endtask

  // Test sequence.
  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) drive_beat(dir_tab[i].b, dir_tab[i].pin);

    // Shortest window that can suppress.
    write_window(16'd1);
    random_phase(300);

    // Longest window.
    write_window(16'd65535);
    random_phase(300);

    // A zero window never suppresses.
    write_window(16'd0);
    random_phase(250);

    // Random window, with neither side idling.
    idle_off = 1'b1;
    write_window(16'($urandom_range(65535, 1)));
    random_phase(250);
    idle_off = 1'b0;

    write_window(16'($urandom_range(5000, 1)));
    random_phase(300);

    in_valid <= 1'b0;
    while (expected_sends.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("[repeat_payload_suppressor] OK");
    end else begin
      $display("[repeat_payload_suppressor] ERROR");
    end
    $finish;
  end

endmodule
